// ===== rtl/core/crast_pkg.sv =====
// ============================================================================
// Circle rasterizer package
// Shared constants and reset values for the circle rasterizer.
// ============================================================================
`default_nettype none

package crast_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_W        = 24;
    localparam int SCREEN_W       = 11;
    localparam int QUEUE_DEPTH    = 2;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 4;

    localparam logic [COLOR_W-1:0]  COLOR_RESET  = 24'hFFFFFF;
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 11'd600;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 11'd600;

    localparam int DEC_INIT  = 3;
    localparam int STEP_DIAG = 10;
    localparam int STEP_AXIS = 6;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] REG_DRAW_COLOR    = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/crast_front.sv =====
// ============================================================================
// Circle rasterizer front end
// Accepts commands, advances the midpoint state and queues one point per beat.
// ============================================================================
`default_nettype none

module crast_front #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_command,
    input  wire logic [COORD_BITS-1:0]   i_center_x,
    input  wire logic [COORD_BITS-1:0]   i_center_y,
    input  wire logic [COORD_BITS-1:0]   i_radius,
    input  wire logic                    i_full,
    output logic                         o_push,
    output logic [4*COORD_BITS:0]        o_rec
);
    import crast_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 4;
    localparam int EW = COORD_BITS + 2;

    logic [CW-1:0] r_x, r_y, r_cx, r_cy;
    logic [CW-1:0] n_x, n_y, n_cx, n_cy;
    logic [DW-1:0] r_d, n_d;
    logic          r_active, n_active;
    logic          accept, cur_pos, nxt_pos, is_final;
    logic [DW-1:0] dx, dy, dr;
    logic [EW-1:0] ex, ey;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign dx      = DW'(r_x);
    assign dy      = DW'(r_y);
    assign dr      = DW'(i_radius);
    assign cur_pos = !r_d[DW-1] && (r_d != '0);

    always_comb begin
        n_x  = r_x;
        n_y  = r_y;
        n_d  = r_d;
        n_cx = r_cx;
        n_cy = r_cy;
        if (i_command == CMD_START) begin
            n_cx = i_center_x;
            n_cy = i_center_y;
            n_x  = '0;
            n_y  = i_radius;
            n_d  = DW'(DEC_INIT) - (dr << 1);
        end else if (cur_pos) begin
            n_d = r_d + ((dx - dy) << 2) + DW'(STEP_DIAG);
            n_y = r_y - 1'b1;
            n_x = r_x + 1'b1;
        end else begin
            n_d = r_d + (dx << 2) + DW'(STEP_AXIS);
            n_x = r_x + 1'b1;
        end
        nxt_pos  = !n_d[DW-1] && (n_d != '0);
        ex       = EW'(n_x) + EW'(1);
        ey       = EW'(n_y) - EW'(nxt_pos);
        is_final = $signed(ex) > $signed(ey);
        n_active = !is_final;
    end

    assign o_push = accept && ((i_command == CMD_START) || r_active);
    assign o_rec  = {n_cx, n_cy, n_x, n_y, is_final};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_active <= 1'b0;
        end else if (o_push) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crast_queue.sv =====
// ============================================================================
// Circle rasterizer point queue
// Short first-in first-out buffer of point records between front and back.
// ============================================================================
`default_nettype none

module crast_queue #(
    parameter int WIDTH = 41,
    parameter int DEPTH = crast_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crast_back.sv =====
// ============================================================================
// Circle rasterizer back end
// Expands each queued point into eight mirrored pixel beats, one per cycle while not stalled.
// ============================================================================
`default_nettype none

module crast_back #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_empty,
    input  wire logic [4*COORD_BITS:0]           i_rec,
    output logic                                 o_pop,
    input  wire logic [crast_pkg::COLOR_W-1:0]   i_color,
    input  wire logic [crast_pkg::SCREEN_W-1:0]  i_width,
    input  wire logic [crast_pkg::SCREEN_W-1:0]  i_height,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [COORD_BITS+1:0]         o_pixel_x,
    output logic signed [COORD_BITS+1:0]         o_pixel_y,
    output logic [crast_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic                                 o_on_screen,
    output logic                                 o_last_of_run,
    output logic                                 o_circle_done
);
    import crast_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int PW = COORD_BITS + 2;
    localparam int MW = (PW > SCREEN_W) ? PW : SCREEN_W;

    logic [CW-1:0]      cx, cy, ox, oy, off_a, off_b;
    logic               rec_final, load, last, visible;
    logic [2:0]         r_k;
    logic [PW-1:0]      px, py;
    logic               r_valid;
    logic [PW-1:0]      r_px, r_py;
    logic [COLOR_W-1:0] r_color;
    logic               r_on, r_last, r_done;

    assign {cx, cy, ox, oy, rec_final} = i_rec;

    assign load  = !i_empty && (!r_valid || !i_stall);
    assign last  = (r_k == 3'd7);
    assign o_pop = load && last;

    always_comb begin
        off_a   = r_k[2] ? oy : ox;
        off_b   = r_k[2] ? ox : oy;
        px      = r_k[0] ? PW'(cx) - PW'(off_a) : PW'(cx) + PW'(off_a);
        py      = r_k[1] ? PW'(cy) - PW'(off_b) : PW'(cy) + PW'(off_b);
        visible = !px[PW-1] && !py[PW-1] &&
                  (MW'(px) < MW'(i_width)) && (MW'(py) < MW'(i_height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= r_k + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px    <= px;
            r_py    <= py;
            r_color <= i_color;
            r_on    <= visible;
            r_last  <= last;
            r_done  <= last && rec_final;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_color;
    assign o_on_screen   = r_on;
    assign o_last_of_run = r_last;
    assign o_circle_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/circle_rasterizer.sv =====
// ============================================================================
// Circle rasterizer
// Midpoint circle generator with eight-way mirroring and an APB register port.
// ============================================================================
// A start command, or a step command while a circle is being drawn, produces
// eight pixel beats, one per clock cycle while the output is not stalled, so
// the rate of such commands that the block sustains is set by the single
// pixel output port of the back end. Commands are taken while the two-entry
// point queue has room, and a step command while idle produces no beat. The
// last beat of each point has the run flag set, and the last beat of the
// final point also has the circle-done flag set.
`default_nettype none

module circle_rasterizer #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [crast_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [crast_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [crast_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                     pready,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_command,
    input  wire logic [COORD_BITS-1:0]               i_center_x,
    input  wire logic [COORD_BITS-1:0]               i_center_y,
    input  wire logic [COORD_BITS-1:0]               i_radius,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [COORD_BITS+1:0]             o_pixel_x,
    output logic signed [COORD_BITS+1:0]             o_pixel_y,
    output logic [crast_pkg::COLOR_W-1:0]            o_pixel_color,
    output logic                                     o_on_screen,
    output logic                                     o_last_of_run,
    output logic                                     o_circle_done
);
    import crast_pkg::*;

    localparam int RW = 4 * COORD_BITS + 1;

    logic [COLOR_W-1:0]  r_color;
    logic [SCREEN_W-1:0] r_width, r_height;
    logic [1:0]          reg_idx;
    logic                wr_en;
    logic                push, pop, full, empty;
    logic [RW-1:0]       rec_in, rec_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= COLOR_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DRAW_COLOR:    r_color  <= pwdata[COLOR_W-1:0];
                REG_SCREEN_WIDTH:  r_width  <= pwdata[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: r_height <= pwdata[SCREEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DRAW_COLOR:    prdata = APB_DATA_W'(r_color);
            REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:           prdata = '0;
        endcase
    end

    crast_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_command  (i_command),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_full     (full),
        .o_push     (push),
        .o_rec      (rec_in)
    );

    crast_queue #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (rec_out)
    );

    crast_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_rec         (rec_out),
        .o_pop         (pop),
        .i_color       (r_color),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_on_screen   (o_on_screen),
        .o_last_of_run (o_last_of_run),
        .o_circle_done (o_circle_done)
    );

endmodule

`default_nettype wire

// ===== rtl/core/crast_checker.sv =====
// ============================================================================
// Circle rasterizer checker
// Port-level properties of the circle rasterizer, bound to the top level.
// ============================================================================
`default_nettype none

module crast_checker #(
    parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              pready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic signed [COORD_BITS+1:0]      o_pixel_x,
    input wire logic signed [COORD_BITS+1:0]      o_pixel_y,
    input wire logic                              o_last_of_run,
    input wire logic                              o_circle_done
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat shown right after reset");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_circle_done |-> o_last_of_run)
        else $error("circle done flag on a beat that does not end a run");

    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=> o_out_valid)
        else $error("gap inside a run of eight pixel beats");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y))
        else $error("stalled pixel beat changed");

    a_ready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind circle_rasterizer crast_checker #(
    .COORD_BITS (COORD_BITS)
) u_crast_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_last_of_run (o_last_of_run),
    .o_circle_done (o_circle_done)
);

`default_nettype wire
